FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by palette_downscale_rgb565_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PDS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Trigger in one cycle implies the consequence in the following cycle.
`define PDS_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pds565_pkg.sv
// ----------------------------------------------------------------------------
// pds565_pkg
// Types, constants and the color packing function of the palette downscaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pds565_pkg;

	localparam int SOURCE_WIDTH_DEF = 320;
	localparam int PANEL_WIDTH_DEF  = 160;
	localparam int PANEL_HEIGHT_DEF = 128;
	localparam int IMAGE_ROWS_DEF   = 100;

	localparam int PAL_DEPTH = 256;
	localparam int PAL_WIDTH = 24;
	localparam int PAL_AW    = 8;

	localparam logic [4:0] ROW_OFFSET_RESET = 5'd14;
	localparam logic [7:0] ROW_MAX          = 8'hff;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] palette_slot;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] pixel_value;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  dest_x;
		logic [6:0]  dest_y;
		logic [15:0] pixel_color;
		logic        last_of_frame;
	} out_item_t;

	// Palette entry holds red in 23..16, green in 15..8, blue in 7..0.
	function automatic logic [15:0] to_rgb565(input logic [PAL_WIDTH-1:0] entry);
		to_rgb565 = {entry[23:19], entry[15:10], entry[7:3]};
	endfunction

endpackage

FILE: rtl/palette_downscale_rgb565_unit.sv
// ----------------------------------------------------------------------------
// palette_downscale_rgb565_unit
// Indexed-color source pixels to mirrored, 2:1 decimated RGB565 panel pixels.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid / in_ready       in_data  (in_item_t)
//   out       output     out_valid / out_ready     out_data (out_item_t)
//   cfg       input      cfg_we                    cfg_data (row_offset)
//
// One item is accepted per cycle while in_ready is high; s1 holding a stalled
// pixel drops it. A kept pixel is registered by the palette RAM read and s1 at
// the accepting edge, then by the output register, which loads when it is empty
// or out_ready is high. s1 and the output register let one new request enter
// while a result waits. Reset clears the counters and valid flags and sets
// row_offset to 14; the palette RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module palette_downscale_rgb565_unit #(
	parameter int SOURCE_WIDTH = pds565_pkg::SOURCE_WIDTH_DEF,
	parameter int PANEL_WIDTH  = pds565_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = pds565_pkg::PANEL_HEIGHT_DEF,
	parameter int IMAGE_ROWS   = pds565_pkg::IMAGE_ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pds565_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pds565_pkg::out_item_t out_data,
	input  logic                  cfg_we,
	input  logic [4:0]            cfg_data
);

	import pds565_pkg::*;

	localparam int CW = $clog2(SOURCE_WIDTH);

	logic [CW-1:0]        col_q;
	logic [7:0]           row_q;
	logic [4:0]           row_offset_q;

	logic                 accept;
	logic                 pix_accept;
	logic                 load_accept;
	logic [CW-1:0]        col_cur;
	logic [7:0]           row_cur;
	logic [CW-1:0]        mirrored;
	logic [CW-2:0]        dx;
	logic [8:0]           dy;
	logic                 keep;
	logic                 last;

	logic                 valid_s1;
	logic [7:0]           dest_x_s1;
	logic [6:0]           dest_y_s1;
	logic                 last_s1;
	logic                 move_s1;
	logic [PAL_WIDTH-1:0] pal_rdata;

	logic                 out_valid_q;
	out_item_t            out_q;

	assign move_s1     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready    = !valid_s1 || move_s1;
	assign accept      = in_valid && in_ready;
	assign pix_accept  = accept && (in_data.operation == OP_PIXEL);
	assign load_accept = accept && (in_data.operation == OP_LOAD);

	always_comb begin
		col_cur  = in_data.frame_start ? '0 : col_q;
		row_cur  = in_data.frame_start ? '0 : row_q;
		mirrored = CW'(SOURCE_WIDTH - 1) - col_cur;
		dx       = mirrored[CW-1:1];
		dy       = {2'b00, row_cur[7:1]} + {4'b0000, row_offset_q};
		keep     = !row_cur[0] && (32'(row_cur) < 32'(2 * IMAGE_ROWS))
			&& !mirrored[0] && (32'(dx) < 32'(PANEL_WIDTH))
			&& (32'(dy) < 32'(PANEL_HEIGHT));
		last     = (32'(row_cur) == 32'(2 * IMAGE_ROWS - 2))
			&& (32'(col_cur) == 32'(SOURCE_WIDTH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			row_offset_q <= ROW_OFFSET_RESET;
		end else begin
			if (cfg_we) begin
				row_offset_q <= cfg_data;
			end
			if (pix_accept) begin
				if (32'(col_cur) == 32'(SOURCE_WIDTH - 1)) begin
					col_q <= '0;
					row_q <= (row_cur == ROW_MAX) ? row_cur : row_cur + 8'd1;
				end else begin
					col_q <= col_cur + CW'(1);
					row_q <= row_cur;
				end
			end
		end
	end

	// The read only fires when s1 is empty or handing off, so the read data
	// holds steady for as long as s1 stalls.
	pds565_ram #(
		.WIDTH(PAL_WIDTH),
		.DEPTH(PAL_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (load_accept),
		.waddr(in_data.palette_slot),
		.wdata({in_data.red, in_data.green, in_data.blue}),
		.re   (pix_accept),
		.raddr(in_data.pixel_value),
		.rdata(pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= pix_accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			dest_x_s1 <= 8'(dx);
			dest_y_s1 <= dy[6:0];
			last_s1   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_q.dest_x        <= dest_x_s1;
			out_q.dest_y        <= dest_y_s1;
			out_q.pixel_color   <= to_rgb565(pal_rdata);
			out_q.last_of_frame <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PDS_ASSERT(a_col_range, clk, arst_n, 32'(col_q) < 32'(SOURCE_WIDTH), "column counter out of range")
	`PDS_ASSERT(a_last_at_edge, clk, arst_n, !(out_valid_q && out_q.last_of_frame) || (out_q.dest_x == 8'd0), "last pixel not at panel column zero")
	`PDS_ASSERT_NEXT(a_frame_restart, clk, arst_n, pix_accept && in_data.frame_start, (col_q == CW'(1)) && (row_q == 8'd0), "frame start did not restart counters")
	`PDS_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !move_s1, valid_s1, "stalled stage lost its pixel")
	`PDS_ASSERT_NEXT(a_load_silent, clk, arst_n, load_accept && !valid_s1, !valid_s1, "palette load produced a pixel")

endmodule

FILE: rtl/pds565_ram.sv
// ----------------------------------------------------------------------------
// pds565_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pds565_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
